// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtpd assertion failed");

`endif

// ===== sv/vtpd_pkg.sv =====
package vtpd_pkg;

  localparam int COORD_W    = 32;
  localparam int SUM_W      = 66;
  localparam int MAG_W      = 65;
  localparam int Q_W        = 32;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_W      = 64;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [CFG_W-1:0]          cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  typedef struct packed {
    logic [Q_W-1:0] quot;
    logic           ovf;
    logic           neg;
  } div_res_t;

endpackage

// ===== sv/vertex_transform_perspective_divide_unit.sv =====
// Vertex transform with perspective divide.
// The input channel (in_valid, in_stall, in_x, in_y, in_z) takes one point in
// signed fixed point with FRAC_BITS fraction bits. The point is multiplied as
// a row vector (x, y, z, 1) by the 4x4 matrix in the eight configuration
// registers, and x', y' and z' are divided by w.
// The result channel (out_valid, out_stall, out_x, out_y, out_z, out_w_zero,
// out_saturated) gives one word per point, in order.
// The configuration port writes one 64-bit matrix register per cycle while
// cfg_wr_en is high; indexes above seven are ignored.
// A point enters in every cycle unless the pipeline stalls, so throughput
// is then one word per clock. Stages: one input register, a multiply stage,
// two adder stages, a sign and magnitude stage, a 33-stage restoring divider
// (an overflow check, then one quotient bit per stage) and the output register.
// Reset clears all valid bits and loads the identity matrix. When the receiver
// stalls a valid output word, the whole pipeline holds and in_stall is raised.
module vertex_transform_perspective_divide_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vtpd_pkg::coord_t    in_x,
  input  vtpd_pkg::coord_t    in_y,
  input  vtpd_pkg::coord_t    in_z,
  output logic                out_valid,
  input  logic                out_stall,
  output vtpd_pkg::coord_t    out_x,
  output vtpd_pkg::coord_t    out_y,
  output vtpd_pkg::coord_t    out_z,
  output logic                out_w_zero,
  output logic                out_saturated,
  input  logic                cfg_wr_en,
  input  vtpd_pkg::cfg_idx_t  cfg_index,
  input  vtpd_pkg::cfg_word_t cfg_data
);
  import vtpd_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;
  localparam cfg_word_t ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam cfg_word_t ONE_HI = CFG_W'(1) << (FRAC_BITS + COORD_W);

  cfg_word_t mat_r [0:NUM_REGS-1];
  logic      pipe_en;

  assign pipe_en  = !out_valid || !out_stall;
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_r[i] <= '0;
      end
      mat_r[0] <= ONE_LO;
      mat_r[2] <= ONE_HI;
      mat_r[5] <= ONE_LO;
      mat_r[7] <= ONE_HI;
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  coord_t m [0:3][0:3];
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = mat_r[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
    end
  end

  // Stage 1: input register.
  logic   v1_r;
  coord_t p_r [0:2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p_r[0] <= in_x;
      p_r[1] <= in_y;
      p_r[2] <= in_z;
    end
  end

  // Stage 2: products.
  logic                v2_r;
  logic signed [63:0]  prod_r [0:3][0:2];
  sum_t                trans_r [0:3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v2_r <= v1_r;
    end
  end
  for (genvar c = 0; c < 4; c++) begin : g_mul
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[c][r] <= 64'(p_r[r]) * 64'(m[r][c]);
        end
        trans_r[c] <= SUM_W'(m[3][c]) <<< FRAC_BITS;
      end
    end
  end

  // Stages 3 and 4: exact column sums.
  logic v3_r, v4_r;
  sum_t sa_r [0:3];
  sum_t sb_r [0:3];
  sum_t sum_r [0:3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 4; c++) begin
        sa_r[c]  <= SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]);
        sb_r[c]  <= SUM_W'(prod_r[c][2]) + trans_r[c];
        sum_r[c] <= sa_r[c] + sb_r[c];
      end
    end
  end

  // Stage 5: signs and magnitudes.
  logic v5_r, wz5_r;
  mag_t mag_r [0:3];
  logic neg_r [0:2];
  sum_t abs_w [0:3];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      abs_w[c] = sum_r[c][SUM_W-1] ? -sum_r[c] : sum_r[c];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (pipe_en) begin
      v5_r <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 4; c++) begin
        mag_r[c] <= abs_w[c][MAG_W-1:0];
      end
      for (int c = 0; c < 3; c++) begin
        neg_r[c] <= sum_r[c][SUM_W-1] ^ sum_r[3][SUM_W-1];
      end
      wz5_r <= (sum_r[3] == '0);
    end
  end

  // Divider lanes with matching valid and w-zero delay lines.
  div_res_t res [0:2];
  for (genvar c = 0; c < 3; c++) begin : g_div
    vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (pipe_en),
      .num_i (NW'(mag_r[c]) << FRAC_BITS),
      .den_i (mag_r[3]),
      .neg_i (neg_r[c]),
      .res_o (res[c])
    );
  end

  logic dv_r [0:DIV_STAGES-1];
  logic dz_r [0:DIV_STAGES-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      dv_r[0] <= v5_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dz_r[0] <= wz5_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dz_r[i] <= dz_r[i-1];
      end
    end
  end

  // Output stage: sign, saturation and the w-zero override.
  coord_t val_w [0:2];
  logic   sat_w [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_w[c] = 1'b0;
      val_w[c] = '0;
      if (!res[c].neg) begin
        if (res[c].ovf || (res[c].quot > SAT_POS)) begin
          sat_w[c] = 1'b1;
          val_w[c] = SAT_POS;
        end else begin
          val_w[c] = res[c].quot;
        end
      end else begin
        if (res[c].ovf || (res[c].quot > SAT_NEG)) begin
          sat_w[c] = 1'b1;
          val_w[c] = SAT_NEG;
        end else begin
          val_w[c] = -res[c].quot;
        end
      end
    end
  end

  logic   out_valid_r, wz_out_r, sat_out_r;
  coord_t ox_r, oy_r, oz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= dv_r[DIV_STAGES-1];
    end
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      wz_out_r  <= dz_r[DIV_STAGES-1];
      sat_out_r <= !dz_r[DIV_STAGES-1] && (sat_w[0] || sat_w[1] || sat_w[2]);
      ox_r      <= dz_r[DIV_STAGES-1] ? '0 : val_w[0];
      oy_r      <= dz_r[DIV_STAGES-1] ? '0 : val_w[1];
      oz_r      <= dz_r[DIV_STAGES-1] ? '0 : val_w[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_w_zero    = wz_out_r;
  assign out_saturated = sat_out_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;

`include "assert_macros.svh"

  `VTPD_ASSERT_IMPL(a_wz_zero, out_valid && out_w_zero, (out_x == '0) && (out_y == '0) && (out_z == '0))
  `VTPD_ASSERT_IMPL(a_sat_excl, out_valid && out_saturated, !out_w_zero)
  `VTPD_ASSERT_IMPL(a_stall_rel, 1'b1, in_stall == (out_valid && out_stall))
  `VTPD_ASSERT_NEXT(a_hold_flags, out_valid && out_stall, out_valid && $stable(out_saturated))

endmodule

// ===== sv/vtpd_div.sv =====
module vtpd_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [vtpd_pkg::MAG_W+FRAC_BITS-1:0]  num_i,
  input  vtpd_pkg::mag_t                        den_i,
  input  logic                                  neg_i,
  output vtpd_pkg::div_res_t                    res_o
);
  import vtpd_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;

  mag_t           rem_r [0:Q_W];
  mag_t           den_r [0:Q_W];
  logic [Q_W-1:0] low_r [0:Q_W];
  logic [Q_W-1:0] quo_r [0:Q_W];
  logic           ovf_r [0:Q_W];
  logic           neg_r [0:Q_W];

  mag_t hi_nxt;
  assign hi_nxt = MAG_W'(num_i[NW-1:Q_W]);

  // The quotient needs more than 32 bits when the high part alone reaches the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_nxt;
      den_r[0] <= den_i;
      low_r[0] <= num_i[Q_W-1:0];
      quo_r[0] <= '0;
      ovf_r[0] <= (hi_nxt >= den_i);
      neg_r[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;
    assign trial = {rem_r[k-1], low_r[k-1][Q_W-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        den_r[k] <= den_r[k-1];
        low_r[k] <= {low_r[k-1][Q_W-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][Q_W-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign res_o.quot = quo_r[Q_W];
  assign res_o.ovf  = ovf_r[Q_W];
  assign res_o.neg  = neg_r[Q_W];

endmodule

// ===== verif/tb.sv =====
module tb;
  import vtpd_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 39;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int RAND_PER_PHASE = 150;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_zero;
    logic   sat;
  } point_res_t;

  typedef struct {
    int     ph;
    coord_t x;
    coord_t y;
    coord_t z;
    bit     typed;
    coord_t ex;
    coord_t ey;
    coord_t ez;
    logic   ewz;
    logic   esat;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_x = '0;
  coord_t in_y = '0;
  coord_t in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic out_w_zero;
  logic out_saturated;
  logic cfg_wr_en = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_word_t cfg_data = '0;

  logic [63:0] matrix_regs [NUM_REGS];
  point_res_t pending_points [$];
  int idle_pct = 25;
  int cycles = 0;
  bit failed = 0;

  vertex_transform_perspective_divide_unit #(.FRAC_BITS(FRAC)) uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic logic signed [127:0] mat_entry(int r, int c);
    logic [63:0] rv;
    rv = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? $signed(rv[63:32]) : $signed(rv[31:0]);
  endfunction

  function automatic logic signed [127:0] column_sum(coord_t x, coord_t y, coord_t z, int c);
    logic signed [127:0] px;
    logic signed [127:0] py;
    logic signed [127:0] pz;
    px = x;
    py = y;
    pz = z;
    return px * mat_entry(0, c) + py * mat_entry(1, c) + pz * mat_entry(2, c)
           + (mat_entry(3, c) <<< FRAC);
  endfunction

  function automatic coord_t divide_sat(logic signed [127:0] num, logic signed [127:0] den,
                                        ref logic sat);
    logic neg;
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    neg = num[127] ^ den[127];
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << FRAC) / d;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return SAT_POS;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      return SAT_NEG;
    end
    return -q[31:0];
  endfunction

  function automatic point_res_t project_point(coord_t x, coord_t y, coord_t z);
    point_res_t r;
    logic signed [127:0] w;
    logic sat;
    sat = 1'b0;
    w = column_sum(x, y, z, 3);
    r = '{x: '0, y: '0, z: '0, w_zero: 1'b0, sat: 1'b0};
    if (w == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    r.x = divide_sat(column_sum(x, y, z, 0), w, sat);
    r.y = divide_sat(column_sum(x, y, z, 1), w, sat);
    r.z = divide_sat(column_sum(x, y, z, 2), w, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic write_reg(int idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= cfg_idx_t'(idx);
    cfg_data <= val;
    if (idx < NUM_REGS) matrix_regs[idx] = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit typed, point_res_t exp_res);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points.push_back(typed ? exp_res : project_point(x, y, z));
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return ONE;
        endcase
      end
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected output word");
        failed = 1;
      end else begin
        e = pending_points.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x);
          failed = 1;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y);
          failed = 1;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z);
          failed = 1;
        end
        if (out_w_zero !== e.w_zero) begin
          $error("out_w_zero expected %b actual %b", e.w_zero, out_w_zero);
          failed = 1;
        end
        if (out_saturated !== e.sat) begin
          $error("out_saturated expected %b actual %b", e.sat, out_saturated);
          failed = 1;
        end
      end
    end
  end

  vec_row_t dir_rows [] = '{
    '{0, 32'sd0, 32'sd0, 32'sd0, 1, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0, 1'b0},
    '{0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA, 1,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA, 1'b0, 1'b0},
    '{0, 32'h1234_5678, 32'hFEDC_BA98, 32'h8000_0000, 1,
      32'h1234_5678, 32'hFEDC_BA98, 32'h8000_0000, 1'b0, 1'b0},
    '{1, 32'h0001_0000, 32'h0002_0000, 32'sd0, 1, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0},
    '{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 1, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0},
    '{1, 32'h7FFF_FFFF, 32'sd0, 32'sd1, 1, SAT_POS, 32'sd0, ONE, 1'b0, 1'b1},
    '{1, 32'h8000_0000, 32'sd0, 32'sd1, 1, SAT_NEG, 32'sd0, ONE, 1'b0, 1'b1},
    '{1, 32'h0003_0000, 32'hFFFA_0000, 32'h0002_0000, 0, '0, '0, '0, 1'b0, 1'b0},
    '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, '0, '0, '0, 1'b0, 1'b0},
    '{1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0, '0, '0, 1'b0, 1'b0},
    '{2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0, '0, '0, 1'b0, 1'b0},
    '{2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0, '0, '0, 1'b0, 1'b0},
    '{2, 32'h0001_0000, 32'hFFFF_0000, 32'sd0, 0, '0, '0, '0, 1'b0, 1'b0},
    '{3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, '0, '0, '0, 1'b0, 1'b0},
    '{3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0, '0, '0, 1'b0, 1'b0},
    '{3, 32'sd0, 32'sd0, 32'sd0, 0, '0, '0, '0, 1'b0, 1'b0}
  };

  initial begin
    int ph;
    point_res_t er;
    for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
    matrix_regs[0] = 64'(ONE);
    matrix_regs[2] = {ONE, 32'h0};
    matrix_regs[5] = 64'(ONE);
    matrix_regs[7] = {ONE, 32'h0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    ph = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].ph != ph) begin
        drain();
        ph = dir_rows[i].ph;
        case (ph)
          1: begin
            write_reg(5, {ONE, ONE});
            write_reg(7, 64'h0);
          end
          2: for (int k = 0; k < NUM_REGS; k++) write_reg(k, 64'h8000_0000_8000_0000);
          default: for (int k = 0; k < NUM_REGS; k++) write_reg(k, 64'h7FFF_FFFF_7FFF_FFFF);
        endcase
      end
      er = '{x: dir_rows[i].ex, y: dir_rows[i].ey, z: dir_rows[i].ez,
             w_zero: dir_rows[i].ewz, sat: dir_rows[i].esat};
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed, er);
    end
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      for (int k = 0; k < NUM_REGS; k++) write_reg(k, {rand_value(), rand_value()});
      if (p % 3 == 1) write_reg(7, {32'h0, rand_value()});
      write_reg($urandom_range(NUM_REGS, 15), {$urandom, $urandom});
      idle_pct = (p == 4) ? 0 : 25;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_point(rand_value(), rand_value(), ($urandom_range(9) == 0) ? 32'h0 : rand_value(),
                   0, er);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== vertex_transform_perspective_divide_unit.f =====
+incdir+sv
sv/vtpd_pkg.sv
sv/vtpd_div.sv
sv/vertex_transform_perspective_divide_unit.sv
verif/tb.sv
